FILE: rtl/rrs_pkg.sv
// ----------------------------------------------------------------------------
// rrs_pkg: shared types and constants for the round-robin slice scheduler
// Holds the event codes, task states, controller states and command and status structs.
// ----------------------------------------------------------------------------
`default_nettype none
package rrs_pkg;
  localparam int MaxTasksDef = 16;
  localparam int TickMsDef = 10;
  localparam logic [7:0] SliceReset = 8'd10;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_YIELD  = 2'd1,
    FUNC_SLEEP  = 2'd2,
    FUNC_CREATE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    TS_NONE  = 2'd0,
    TS_READY = 2'd1,
    TS_SLEEP = 2'd2
  } task_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_FINISH,
    S_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic exec;     // run the first step of the held request
    logic walk;     // process one sleep entry
    logic finish;   // commit sleep list size, final dispatch
  } rrs_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic walk_done;
  } rrs_stat_t;
endpackage
`default_nettype wire

FILE: rtl/rrs_if.sv
// ----------------------------------------------------------------------------
// rrs_in_if / rrs_out_if: valid-ready channels for requests and results
// Each carries valid, ready and the payload fields.
// ----------------------------------------------------------------------------
`default_nettype none
interface rrs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [3:0]  task_id;
  logic [15:0] sleep_ms;
  modport source (output valid, func, task_id, sleep_ms, input ready);
  modport sink (input valid, func, task_id, sleep_ms, output ready);
endinterface

interface rrs_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] current_task;
  logic       switched;
  logic [4:0] ready_count;
  logic       status;
  modport source (output valid, current_task, switched, ready_count, status,
                  input ready);
  modport sink (input valid, current_task, switched, ready_count, status,
                output ready);
endinterface
`default_nettype wire

FILE: rtl/rrs_ctrl.sv
// ----------------------------------------------------------------------------
// rrs_ctrl: request sequencer
// Accepts a request, steps the datapath through it, and presents the result.
// ----------------------------------------------------------------------------
`default_nettype none
module rrs_ctrl
  import rrs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire rrs_stat_t stat,
  output rrs_cmd_t       cmd
);
  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_next = stat.is_tick ? S_WALK : S_OUT;
      end
      S_WALK: begin
        if (stat.walk_done) begin
          state_next = S_FINISH;
        end else begin
          cmd.walk = 1'b1;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.exec, cmd.walk, cmd.finish})) else $error("multiple commands");
  a_exec_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> cmd.exec) else $error("accept not followed by exec");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("accept while result pending");
endmodule
`default_nettype wire

FILE: rtl/rrs_dp.sv
// ----------------------------------------------------------------------------
// rrs_dp: scheduler datapath
// Ready FIFO, sleep list, slice counters, task states and the result fields.
// ----------------------------------------------------------------------------
`default_nettype none
module rrs_dp
  import rrs_pkg::*;
#(
  parameter int MAX_TASKS = MaxTasksDef,
  parameter int TICK_MS = TickMsDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        accept,
  input  wire logic [1:0]  func,
  input  wire logic [3:0]  task_id,
  input  wire logic [15:0] sleep_ms,
  input  wire rrs_cmd_t    cmd,
  output rrs_stat_t        stat,
  output logic [4:0]       current_task,
  output logic             switched,
  output logic [4:0]       ready_count,
  output logic             status
);
  localparam int IW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam logic [CW-1:0] Full = CW'(MAX_TASKS);
  localparam logic [CW-1:0] Idle = CW'(MAX_TASKS);
  localparam logic [16:0] TickM1 = 17'(TICK_MS - 1);
  // reciprocal of the tick length, exact for any 17-bit numerator
  localparam int RecipShift = 17 + $clog2(TICK_MS);
  localparam longint RecipMul =
      ((longint'(1) << RecipShift) + longint'(TICK_MS) - 1) / longint'(TICK_MS);
  localparam logic [18:0] TickRecip = 19'(RecipMul);

  logic [7:0]    slice_length;
  logic [IW-1:0] rq [MAX_TASKS];
  logic [IW-1:0] so [MAX_TASKS];
  logic [15:0]   sl [MAX_TASKS];
  logic [7:0]    slc [MAX_TASKS+1];
  task_state_t   ts [MAX_TASKS];
  logic [IW-1:0] head;
  logic [CW-1:0] rsize, ssize, widx, wout;
  logic [CW-1:0] run, run_prev;
  logic [1:0]    func_r;
  logic [3:0]    id_r;
  logic [15:0]   ms_r;
  logic [16:0]   ticks_num;
  logic [35:0]   ticks_prod;
  logic [15:0]   ticks_cnt;
  logic          status_r;

  // tail slot for the current size
  function automatic logic [IW-1:0] slot(input logic [IW-1:0] h, input logic [CW-1:0] n);
    logic [CW:0] s;
    s = {1'b0, CW'(h)} + {1'b0, n};
    if (s >= {1'b0, Full}) s = s - {1'b0, Full};
    return IW'(s);
  endfunction

  function automatic logic [IW-1:0] inc(input logic [IW-1:0] h);
    return (CW'(h) + CW'(1) >= Full) ? '0 : IW'(CW'(h) + CW'(1));
  endfunction

  assign stat.is_tick = (func_t'(func_r) == FUNC_TICK);
  assign stat.walk_done = (widx >= ssize);

  // milliseconds to ticks, rounded up: 17 x 19 bit reciprocal product
  assign ticks_num = {1'b0, ms_r} + TickM1;
  assign ticks_prod = 36'(ticks_num) * 36'(TickRecip);
  assign ticks_cnt = 16'(ticks_prod >> RecipShift);

  logic [IW-1:0] wt;
  logic [15:0]   wl;
  assign wt = so[IW'(widx)];
  assign wl = sl[wt] - 16'd1;
  logic [7:0]    sdec;
  logic [IW:0]   curi;
  assign curi = (run > Idle) ? (IW+1)'(MAX_TASKS) : (IW+1)'(run);
  assign sdec = slc[curi] - 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_length <= SliceReset;
      head <= '0;
      rsize <= '0;
      ssize <= '0;
      run <= Idle;
      for (int i = 0; i <= MAX_TASKS; i++) slc[i] <= SliceReset;
      for (int i = 0; i < MAX_TASKS; i++) ts[i] <= TS_NONE;
    end else begin
      if (cfg_we) slice_length <= cfg_data;
      if (accept) begin
        func_r <= func;
        id_r <= task_id;
        ms_r <= sleep_ms;
        run_prev <= run;
      end
      if (cmd.exec) begin
        widx <= '0;
        wout <= '0;
        status_r <= 1'b0;
        case (func_t'(func_r))
          FUNC_TICK: begin
            if (sdec == 8'd0) begin
              slc[curi] <= slice_length;
              if (run < Idle && rsize != '0) begin
                rq[slot(head, rsize)] <= rq[head];
                head <= inc(head);
                run <= (rsize == CW'(1)) ? CW'(rq[head]) : CW'(rq[inc(head)]);
              end else begin
                run <= (rsize == '0) ? Idle : CW'(rq[head]);
              end
            end else begin
              slc[curi] <= sdec;
              run <= (rsize == '0) ? Idle : CW'(rq[head]);
            end
          end
          FUNC_YIELD: begin
            if (run < Idle && rsize != '0) begin
              rq[slot(head, rsize)] <= rq[head];
              head <= inc(head);
              run <= (rsize == CW'(1)) ? CW'(rq[head]) : CW'(rq[inc(head)]);
            end else begin
              run <= (rsize == '0) ? Idle : CW'(rq[head]);
            end
          end
          FUNC_SLEEP: begin
            if (run >= Idle || rsize == '0) begin
              status_r <= 1'b1;
              run <= (rsize == '0) ? Idle : CW'(rq[head]);
            end else if (ticks_cnt == '0 || ssize >= Full) begin
              rq[slot(head, rsize)] <= rq[head];
              head <= inc(head);
              run <= (rsize == CW'(1)) ? CW'(rq[head]) : CW'(rq[inc(head)]);
            end else begin
              sl[rq[head]] <= ticks_cnt;
              ts[rq[head]] <= TS_SLEEP;
              so[IW'(ssize)] <= rq[head];
              ssize <= ssize + CW'(1);
              head <= inc(head);
              rsize <= rsize - CW'(1);
              run <= (rsize == CW'(1)) ? Idle : CW'(rq[inc(head)]);
            end
          end
          default: begin
            if (32'(id_r) >= MAX_TASKS || ts[IW'(id_r)] != TS_NONE) begin
              status_r <= 1'b1;
            end else begin
              ts[IW'(id_r)] <= TS_READY;
              slc[IW'(id_r)] <= slice_length;
              if (rsize < Full) begin
                rq[slot(head, rsize)] <= IW'(id_r);
                rsize <= rsize + CW'(1);
              end
            end
          end
        endcase
      end
      // one sleeper per cycle: count down, wake or compact
      if (cmd.walk) begin
        sl[wt] <= wl;
        widx <= widx + CW'(1);
        if (wl == '0) begin
          ts[wt] <= TS_READY;
          if (rsize < Full) begin
            rq[slot(head, rsize)] <= wt;
            rsize <= rsize + CW'(1);
          end
        end else begin
          so[IW'(wout)] <= wt;
          wout <= wout + CW'(1);
        end
      end
      if (cmd.finish) begin
        ssize <= wout;
        run <= (rsize == '0) ? Idle : CW'(rq[head]);
      end
    end
  end

  assign current_task = 5'(run);
  assign switched = (func_t'(func_r) != FUNC_CREATE) && (run != run_prev);
  assign ready_count = 5'(rsize);
  assign status = status_r;

  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    rsize <= Full && ssize <= Full) else $error("size overflow");
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.walk |-> widx < ssize) else $error("walk past list");
  a_out_bound: assert property (@(posedge clk) disable iff (rst)
    run <= Idle) else $error("bad running task");
endmodule
`default_nettype wire

FILE: rtl/round_robin_slice_scheduler.sv
// ----------------------------------------------------------------------------
// round_robin_slice_scheduler: round-robin task scheduler with time slices
// Top level joining the request sequencer and the scheduler datapath.
// ----------------------------------------------------------------------------
// One request in, one result out. Yield, sleep and create step from the exec
// state straight to presenting the result; a tick also walks each entry on
// the sleep list (up to MAX_TASKS) and then a finish step, since the datapath
// walks sleepers one a cycle to count them down, wake expired ones and
// compact the list. A new request is taken the cycle after the previous
// result has been taken. slice_length may be written only while no request
// is in flight.
`default_nettype none
module round_robin_slice_scheduler
  import rrs_pkg::*;
#(
  parameter int MAX_TASKS = MaxTasksDef,
  parameter int TICK_MS = TickMsDef
) (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       cfg_we,
  input wire logic [7:0] cfg_data,
  rrs_in_if.sink         req,
  rrs_out_if.source      rsp
);
  rrs_cmd_t  cmd;
  rrs_stat_t stat;

  // sequencer: accept, step, present
  rrs_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .stat(stat), .cmd(cmd)
  );

  // datapath: queues, counters, result fields
  rrs_dp #(.MAX_TASKS(MAX_TASKS), .TICK_MS(TICK_MS)) u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .accept(req.valid && req.ready),
    .func(req.func), .task_id(req.task_id), .sleep_ms(req.sleep_ms),
    .cmd(cmd), .stat(stat),
    .current_task(rsp.current_task), .switched(rsp.switched),
    .ready_count(rsp.ready_count), .status(rsp.status)
  );
endmodule
`default_nettype wire

FILE: dv/rrs_sched_scoreboard.sv
// ----------------------------------------------------------------------------
// rrs_sched_scoreboard: scheduler prediction and result checking
// Mirrors the scheduler state, predicts one result per request and checks
// the results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package rrs_sched_tb_pkg;
  import rrs_pkg::*;

  localparam int NTasks = MaxTasksDef;
  localparam logic [4:0] IdleTask = 5'(MaxTasksDef);

  typedef struct packed {
    logic [4:0] current_task;
    logic       switched;
    logic [4:0] ready_count;
    logic       status;
  } sched_result_t;

  class rrs_sched_scoreboard;
    logic [7:0]    slice_len;
    logic [3:0]    rq [NTasks];
    int            rq_head, rq_size;
    logic [3:0]    sl_order [NTasks];
    int            sl_size;
    logic [15:0]   sl_left [NTasks];
    logic [7:0]    slice_cnt [NTasks+1];
    task_state_t   tstate [NTasks];
    logic [4:0]    running;
    sched_result_t pending [$];
    int            errors;

    function void clear_state();
      slice_len = SliceReset;
      rq_head = 0; rq_size = 0; sl_size = 0;
      running = IdleTask;
      errors = 0;
      for (int i = 0; i < NTasks; i++) begin
        tstate[i] = TS_NONE;
        rq[i] = '0; sl_order[i] = '0; sl_left[i] = '0;
      end
      for (int i = 0; i <= NTasks; i++) slice_cnt[i] = SliceReset;
    endfunction

    function void set_slice(logic [7:0] v);
      slice_len = v;
    endfunction

    function void enqueue(logic [3:0] t);
      if (rq_size < NTasks) begin
        rq[(rq_head + rq_size) % NTasks] = t;
        rq_size++;
      end
    endfunction

    function void dequeue();
      if (rq_size > 0) begin
        rq_head = (rq_head + 1) % NTasks;
        rq_size--;
      end
    endfunction

    function void pick_next();
      running = (rq_size == 0) ? IdleTask : {1'b0, rq[rq_head]};
    endfunction

    function void rotate();
      logic [3:0] t;
      if (running < IdleTask && rq_size > 0) begin
        t = rq[rq_head];
        dequeue();
        enqueue(t);
      end
    endfunction

    function void tick();
      int w;
      logic [3:0] t;
      w = 0;
      slice_cnt[running] = slice_cnt[running] - 8'd1;
      if (slice_cnt[running] == 8'd0) begin
        slice_cnt[running] = slice_len;
        rotate();
      end
      pick_next();
      for (int i = 0; i < sl_size; i++) begin
        t = sl_order[i];
        sl_left[t] = sl_left[t] - 16'd1;
        if (sl_left[t] == 16'd0) begin
          tstate[t] = TS_READY;
          enqueue(t);
        end else begin
          sl_order[w] = t;
          w++;
        end
      end
      sl_size = w;
      pick_next();
    endfunction

    function logic nap(logic [15:0] ms);
      logic [3:0] t;
      int ticks;
      if (running >= IdleTask || rq_size == 0) begin
        pick_next();
        return 1'b1;
      end
      t = rq[rq_head];
      dequeue();
      ticks = (int'(ms) + TickMsDef - 1) / TickMsDef;
      if (ticks == 0 || sl_size >= NTasks) enqueue(t);
      else begin
        sl_left[t] = 16'(ticks);
        tstate[t] = TS_SLEEP;
        sl_order[sl_size] = t;
        sl_size++;
      end
      pick_next();
      return 1'b0;
    endfunction

    // Note an accepted request: advance the state and queue its result.
    function void note_request(func_t f, logic [3:0] id, logic [15:0] ms);
      sched_result_t r;
      logic [4:0] was;
      was = running;
      r.status = 1'b0;
      case (f)
        FUNC_TICK: tick();
        FUNC_YIELD: begin
          rotate();
          pick_next();
        end
        FUNC_SLEEP: r.status = nap(ms);
        default: begin
          if (tstate[id] != TS_NONE) r.status = 1'b1;
          else begin
            tstate[id] = TS_READY;
            slice_cnt[id] = slice_len;
            enqueue(id);
          end
        end
      endcase
      r.current_task = running;
      r.switched = (running != was);
      r.ready_count = 5'(rq_size);
      pending.push_back(r);
    endfunction

    task report(string what, int got, int want);
      $display("[%0t] mismatch %s: got %0d want %0d", $time, what, got, want);
      errors++;
    endtask

    task check_result(sched_result_t got);
      sched_result_t want;
      if (pending.size() == 0) begin
        report("unexpected result", got, 0);
        return;
      end
      want = pending.pop_front();
      if (got.current_task != want.current_task)
        report("current_task", got.current_task, want.current_task);
      if (got.switched != want.switched) report("switched", got.switched, want.switched);
      if (got.ready_count != want.ready_count)
        report("ready_count", got.ready_count, want.ready_count);
      if (got.status != want.status) report("status", got.status, want.status);
    endtask
  endclass
endpackage

FILE: dv/tb_round_robin_slice_scheduler.sv
// ----------------------------------------------------------------------------
// tb_round_robin_slice_scheduler: self-checking bench for the scheduler
// Drives directed and random request streams with random gaps and stalls,
// changes the slice length between phases and checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_round_robin_slice_scheduler;
  import rrs_pkg::*;
  import rrs_sched_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_data = '0;
  rrs_in_if req ();
  rrs_out_if rsp ();

  round_robin_slice_scheduler DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .req(req.sink), .rsp(rsp.source)
  );

  rrs_sched_scoreboard sb;
  int cycles = 0;
  int stall_hold = 0;    // long receiver hold-off requested by the sender side
  int rsp_gap_max = 16;
  localparam int CycleLimit = 1_500_000;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    req.valid = 1'b0; req.func = '0; req.task_id = '0; req.sleep_ms = '0;
    rsp.ready = 1'b0;
  end

  // Cycle count and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: check accepted results, then draw a stall for the next one.
  initial begin : receiver
    int wait_n;
    wait (sb != null);
    forever begin
      @(posedge clk);
      if (rsp.valid && rsp.ready) begin
        sb.check_result({rsp.current_task, rsp.switched, rsp.ready_count, rsp.status});
      end
      if (stall_hold > 0) begin
        // Hold off for a long stretch so the block backs up its input.
        rsp.ready <= 1'b0;
        repeat (stall_hold) @(posedge clk);
        stall_hold = 0;
        rsp.ready <= 1'b1;
      end else if (!rsp.ready || (rsp.valid && rsp.ready)) begin
        wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, rsp_gap_max);
        if (wait_n > 0 && rsp.ready) begin
          rsp.ready <= 1'b0;
          repeat (wait_n) @(posedge clk);
        end
        rsp.ready <= 1'b1;
      end
    end
  end

  int gap_max = 16;

  // Offer one request, wait for it to be taken; idle a random gap first.
  task automatic send_request(func_t f, logic [3:0] id, logic [15:0] ms);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, gap_max);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.func <= f;
    req.task_id <= id;
    req.sleep_ms <= ms;
    do @(posedge clk); while (!req.ready);
    sb.note_request(f, id, ms);
  endtask

  // Drop the request, wait for every expected result, then let the block settle.
  task automatic drain();
    req.valid <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_slice(logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_slice(v);
  endtask

  // Draw a random request, weighted toward ticks and mostly short sleeps.
  task automatic send_random();
    int k;
    logic [15:0] ms;
    k = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) ms = 16'($urandom);
    else ms = 16'($urandom_range(0, 80));
    if (k < 45) send_request(FUNC_TICK, 4'($urandom), ms);
    else if (k < 62) send_request(FUNC_YIELD, 4'($urandom), 16'($urandom));
    else if (k < 80) send_request(FUNC_SLEEP, 4'($urandom), ms);
    else send_request(FUNC_CREATE, 4'($urandom), 16'($urandom));
  endtask

  initial begin : stimulus
    logic [7:0] slices [5];
    sb = new();
    sb.clear_state();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: idle behavior, creates, duplicates, every event kind.
    send_request(FUNC_SLEEP, 4'd0, 16'd50);     // sleep while idle is ignored
    send_request(FUNC_YIELD, 4'd0, 16'd0);      // yield while idle
    send_request(FUNC_TICK, 4'd0, 16'd0);
    send_request(FUNC_CREATE, 4'd0, 16'd0);
    send_request(FUNC_CREATE, 4'd15, 16'hFFFF);
    send_request(FUNC_CREATE, 4'd0, 16'd0);     // duplicate create
    send_request(FUNC_TICK, 4'd0, 16'd0);       // dispatch out of idle
    send_request(FUNC_YIELD, 4'd0, 16'd0);
    send_request(FUNC_SLEEP, 4'd0, 16'd0);      // zero-length sleep requeues
    send_request(FUNC_SLEEP, 4'd0, 16'd1);      // rounds up to one tick
    send_request(FUNC_SLEEP, 4'd0, 16'd10);
    send_request(FUNC_TICK, 4'd0, 16'd0);
    send_request(FUNC_CREATE, 4'd7, 16'd0);
    send_request(FUNC_SLEEP, 4'd0, 16'hFFFF);   // longest sleep
    for (int i = 0; i < 11; i++) send_request(FUNC_TICK, 4'd0, 16'd0);
    drain();

    slices[0] = 8'd1; slices[1] = 8'd255; slices[2] = 8'd3;
    slices[3] = 8'd0; slices[4] = 8'd10;
    for (int p = 0; p < 5; p++) begin
      write_slice(slices[p]);
      // Fill out the task set early so sleeps and rotations happen.
      for (int i = 0; i < 6; i++) send_request(FUNC_CREATE, 4'($urandom), 16'($urandom));
      for (int n = 0; n < 280; n++) begin
        if (p == 1 && n == 40) stall_hold = 300;   // long stall while sending
        if (p == 2 && n == 100) begin
          drain();                                  // sender pauses fully
          gap_max = 0; rsp_gap_max = 0;
        end
        if (p == 2 && n == 180) begin
          gap_max = 16; rsp_gap_max = 16;
        end
        send_random();
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
